// ===== rtl/mslrd_pkg.sv =====
// ----------------------------------------------------------------------------
// mslrd_pkg
// Shared widths, constants and types of the minimal standard range draw.
// ----------------------------------------------------------------------------
package mslrd_pkg;

	localparam int ValW = 31;

	// generator modulus 2^31-1 and multiplier
	localparam logic [ValW-1:0] LcgMod    = '1;
	localparam logic [15:0]     LcgMult   = 16'd48271;
	localparam logic [ValW-1:0] SeedReset = 31'd1;

	// scaling divisor m-1 and twice that, at the width of the partial remainder
	localparam logic [ValW+1:0] ScaleDiv  = 33'h0_7FFF_FFFE;
	localparam logic [ValW+1:0] ScaleDiv2 = 33'h0_FFFF_FFFC;

	localparam int LcgSteps = 16;
	localparam int LcgCntW  = $clog2(LcgSteps);
	localparam int DivSteps = ValW;
	localparam int DivCntW  = $clog2(DivSteps);

	// request kinds
	localparam logic ReqRaw     = 1'b0;
	localparam logic ReqBounded = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} su_stat_t;

endpackage

// ===== rtl/mslrd_if.sv =====
// ----------------------------------------------------------------------------
// mslrd channel interfaces
// Valid/ready channels for seed writes, draw requests and draw results.
// ----------------------------------------------------------------------------
interface mslrd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mslrd_pkg::ValW-1:0]     seed;

	modport source (output valid, output seed, input ready);
	modport sink   (input valid, input seed, output ready);
endinterface

interface mslrd_req_if;
	logic                           valid;
	logic                           ready;
	logic                           req_type;
	logic [mslrd_pkg::ValW-1:0]     low_bound;
	logic [mslrd_pkg::ValW-1:0]     high_bound;

	modport source (output valid, output req_type, output low_bound, output high_bound,
		input ready);
	modport sink   (input valid, input req_type, input low_bound, input high_bound,
		output ready);
endinterface

interface mslrd_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [mslrd_pkg::ValW-1:0]     value;
	logic                           range_error;

	modport source (output valid, output value, output range_error, input ready);
	modport sink   (input valid, input value, input range_error, output ready);
endinterface

// ===== rtl/mslrd_lcg_step.sv =====
// ----------------------------------------------------------------------------
// mslrd_lcg_step
// One generator advance, x*48271 mod 2^31-1, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mslrd_lcg_step (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mslrd_pkg::ValW-1:0]   x,
	output logic [mslrd_pkg::ValW-1:0]   result,
	output mslrd_pkg::su_stat_t          stat
);

	logic                               busy_q;
	logic                               done_q;
	logic [mslrd_pkg::LcgCntW-1:0]      cnt_q;
	logic [mslrd_pkg::ValW-1:0]         acc_q;
	logic [mslrd_pkg::ValW-1:0]         xr_q;
	logic [mslrd_pkg::ValW-1:0]         rot;
	logic [mslrd_pkg::ValW-1:0]         addend;
	logic [mslrd_pkg::ValW:0]           sum;
	logic [mslrd_pkg::ValW-1:0]         acc_nxt;

	// doubling mod 2^31-1 is a rotate
	always_comb begin
		rot     = {acc_q[mslrd_pkg::ValW-2:0], acc_q[mslrd_pkg::ValW-1]};
		addend  = mslrd_pkg::LcgMult[cnt_q] ? xr_q : '0;
		sum     = {1'b0, rot} + {1'b0, addend};
		acc_nxt = (sum >= {1'b0, mslrd_pkg::LcgMod}) ?
			mslrd_pkg::ValW'(sum - {1'b0, mslrd_pkg::LcgMod}) : sum[mslrd_pkg::ValW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mslrd_pkg::LcgCntW'(mslrd_pkg::LcgSteps - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			xr_q  <= (x == mslrd_pkg::LcgMod) ? '0 : x;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
		end
	end

	assign result    = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/mslrd_mod_unit.sv =====
// ----------------------------------------------------------------------------
// mslrd_mod_unit
// Restoring remainder of 2^31-1 by the range width, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mslrd_mod_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mslrd_pkg::ValW-1:0]   divisor,
	output logic [mslrd_pkg::ValW-1:0]   remainder,
	output mslrd_pkg::su_stat_t          stat
);

	logic                               busy_q;
	logic                               done_q;
	logic [mslrd_pkg::DivCntW-1:0]      cnt_q;
	logic [mslrd_pkg::ValW-1:0]         rem_q;
	logic [mslrd_pkg::ValW-1:0]         div_q;
	logic [mslrd_pkg::ValW:0]           trial;
	logic [mslrd_pkg::ValW-1:0]         rem_nxt;

	// every dividend bit of 2^31-1 is one
	always_comb begin
		trial   = {rem_q, 1'b1};
		rem_nxt = (trial >= {1'b0, div_q}) ?
			mslrd_pkg::ValW'(trial - {1'b0, div_q}) : trial[mslrd_pkg::ValW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mslrd_pkg::DivCntW'(mslrd_pkg::DivSteps - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
		end
	end

	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/mslrd_scale_unit.sv =====
// ----------------------------------------------------------------------------
// mslrd_scale_unit
// floor(x*k / (2^31-2)), interleaved shift-add multiply and reduction,
// one bit of k per cycle, most significant first.
// ----------------------------------------------------------------------------
module mslrd_scale_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mslrd_pkg::ValW-1:0]   x,
	input  logic [mslrd_pkg::ValW-1:0]   k,
	output logic [mslrd_pkg::ValW-1:0]   quotient,
	output mslrd_pkg::su_stat_t          stat
);

	logic                               busy_q;
	logic                               done_q;
	logic [mslrd_pkg::DivCntW-1:0]      cnt_q;
	logic [mslrd_pkg::ValW-1:0]         x_q;
	logic [mslrd_pkg::ValW-1:0]         k_q;
	logic [mslrd_pkg::ValW-1:0]         r_q;
	logic [mslrd_pkg::ValW-1:0]         q_q;
	logic [mslrd_pkg::ValW+1:0]         part;
	logic [mslrd_pkg::ValW+1:0]         part_red;
	logic [1:0]                         digit;
	logic [mslrd_pkg::ValW:0]           q_wide;

	// partial remainder stays below the divisor, digit is 0..2
	always_comb begin
		part = {1'b0, r_q, 1'b0} + (k_q[mslrd_pkg::ValW-1] ? {2'b00, x_q} : '0);
		if (part >= mslrd_pkg::ScaleDiv2) begin
			digit    = 2'd2;
			part_red = part - mslrd_pkg::ScaleDiv2;
		end else if (part >= mslrd_pkg::ScaleDiv) begin
			digit    = 2'd1;
			part_red = part - mslrd_pkg::ScaleDiv;
		end else begin
			digit    = 2'd0;
			part_red = part;
		end
		q_wide = {q_q, 1'b0} + {{(mslrd_pkg::ValW-1){1'b0}}, digit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mslrd_pkg::DivCntW'(mslrd_pkg::DivSteps - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			k_q <= k;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			k_q <= {k_q[mslrd_pkg::ValW-2:0], 1'b0};
			r_q <= part_red[mslrd_pkg::ValW-1:0];
			q_q <= q_wide[mslrd_pkg::ValW-1:0];
		end
	end

	assign quotient  = q_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/minimal_standard_lcg_range_draw.sv =====
// ----------------------------------------------------------------------------
// minimal_standard_lcg_range_draw
// Park-Miller generator (multiplier 48271) with raw and bounded draws.
//
//   channel  dir  handshake      payload
//   cfg      in   valid/ready    seed (31)
//   req      in   valid/ready    req_type, low_bound (31), high_bound (31)
//   rsp      out  valid/ready    value (31), range_error
//
// raw draw: one generator advance (16-step serial multiply), then the result
// bounded draw: advance, limit check, scaling, plus one advance per rejected
//   state; the 31-step remainder runs beside the first advance, the 31-step
//   scaling unit after the check; range error: no unit runs; one request in
//   flight, the next one is taken while a finished result waits in the output
//   register; reset loads the state with 1; seed writes are always taken
// ----------------------------------------------------------------------------
module minimal_standard_lcg_range_draw (
	input  logic          clk,
	input  logic          arst_n,
	mslrd_cfg_if.sink     cfg,
	mslrd_req_if.sink     req,
	mslrd_rsp_if.source   rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADV,
		S_LIMIT,
		S_SCALE,
		S_DONE
	} state_t;

	state_t                             state_q;
	logic [mslrd_pkg::ValW-1:0]         draw_state_q;
	logic                               kind_q;
	logic [mslrd_pkg::ValW-1:0]         lo_q;
	logic [mslrd_pkg::ValW-1:0]         k_q;
	logic [mslrd_pkg::ValW-1:0]         res_value_q;
	logic                               res_err_q;
	logic [mslrd_pkg::ValW-1:0]         value_q;
	logic                               err_q;
	logic                               out_valid_q;
	logic                               lcg_go_q;
	logic                               mod_go_q;
	logic                               scl_go_q;

	logic [mslrd_pkg::ValW-1:0]         lcg_res;
	logic [mslrd_pkg::ValW-1:0]         mod_rem;
	logic [mslrd_pkg::ValW-1:0]         scl_q;
	mslrd_pkg::su_stat_t                lcg_stat;
	mslrd_pkg::su_stat_t                mod_stat;
	mslrd_pkg::su_stat_t                scl_stat;
	logic [mslrd_pkg::ValW-1:0]         limit;
	logic                               load_out;

	mslrd_lcg_step u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lcg_go_q),
		.x      (draw_state_q),
		.result (lcg_res),
		.stat   (lcg_stat)
	);

	mslrd_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_go_q),
		.divisor   (k_q),
		.remainder (mod_rem),
		.stat      (mod_stat)
	);

	mslrd_scale_unit u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scl_go_q),
		.x        (draw_state_q),
		.k        (k_q),
		.quotient (scl_q),
		.stat     (scl_stat)
	);

	assign limit    = mslrd_pkg::LcgMod - mod_rem;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign cfg.ready       = 1'b1;
	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.value       = value_q;
	assign rsp.range_error = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			draw_state_q <= mslrd_pkg::SeedReset;
			kind_q       <= mslrd_pkg::ReqRaw;
			lo_q         <= '0;
			k_q          <= '0;
			res_value_q  <= '0;
			res_err_q    <= 1'b0;
			value_q      <= '0;
			err_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			lcg_go_q     <= 1'b0;
			mod_go_q     <= 1'b0;
			scl_go_q     <= 1'b0;
		end else begin
			lcg_go_q <= 1'b0;
			mod_go_q <= 1'b0;
			scl_go_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				draw_state_q <= cfg.seed;
			end
			if (rsp.valid && rsp.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						kind_q <= req.req_type;
						lo_q   <= req.low_bound;
						k_q    <= req.high_bound - req.low_bound;
						if (req.req_type == mslrd_pkg::ReqBounded &&
							req.high_bound <= req.low_bound) begin
							res_value_q <= '0;
							res_err_q   <= 1'b1;
							state_q     <= S_DONE;
						end else begin
							res_err_q <= 1'b0;
							lcg_go_q  <= 1'b1;
							mod_go_q  <= (req.req_type == mslrd_pkg::ReqBounded);
							state_q   <= S_ADV;
						end
					end
				end
				S_ADV: begin
					if (lcg_stat.done) begin
						draw_state_q <= lcg_res;
						if (kind_q == mslrd_pkg::ReqRaw) begin
							res_value_q <= lcg_res;
							state_q     <= S_DONE;
						end else begin
							state_q <= S_LIMIT;
						end
					end
				end
				S_LIMIT: begin
					if (!mod_stat.busy) begin
						if (draw_state_q >= limit) begin
							lcg_go_q <= 1'b1;
							state_q  <= S_ADV;
						end else begin
							scl_go_q <= 1'b1;
							state_q  <= S_SCALE;
						end
					end
				end
				S_SCALE: begin
					if (scl_stat.done) begin
						res_value_q <= lo_q + scl_q;
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						value_q     <= res_value_q;
						err_q       <= res_err_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !lcg_stat.busy && !scl_stat.busy)
		else $error("serial unit busy while idle");

	a_lcg_done_in_adv: assert property (@(posedge clk) disable iff (!arst_n)
		lcg_stat.done |-> state_q == S_ADV)
		else $error("generator step finished outside advance");

	a_mod_done_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		mod_stat.done |-> (state_q == S_ADV || state_q == S_LIMIT))
		else $error("remainder finished outside bounded draw");

	a_scale_done_in_scale: assert property (@(posedge clk) disable iff (!arst_n)
		scl_stat.done |-> state_q == S_SCALE)
		else $error("scaling finished outside scale state");

	a_error_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.range_error |-> rsp.value == '0)
		else $error("range error with nonzero value");

endmodule

// ===== tb/minimal_standard_lcg_range_draw_test.sv =====
// ----------------------------------------------------------------------------
// minimal_standard_lcg_range_draw_test
// Self-checking bench for the minimal standard range draw. A short table of
// directed requests comes first: the bound extremes, range errors, width-one
// ranges and the degenerate seeds. After it come several phases of random
// raw, bounded and malformed requests under different seeds. An in-bench
// generator model predicts each result the table does not fix. Both channels
// stall in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module minimal_standard_lcg_range_draw_test;

	localparam logic [63:0]                  SchrageQ  = 64'd44488;
	localparam logic [63:0]                  SchrageR  = 64'd3399;
	localparam logic [mslrd_pkg::ValW-1:0]   HalfPlus  = 31'h4000_0001;
	localparam logic [mslrd_pkg::ValW-1:0]   TopSeed   = 31'h7FFF_FFFE;
	localparam int                           DirRows   = 24;
	localparam int                           Phases    = 6;
	localparam int                           PhaseReqs = 310;

	typedef struct packed {
		logic [mslrd_pkg::ValW-1:0] value;
		logic                       range_error;
	} draw_result_t;

	// seed rows carry the seed in low_bound
	typedef struct {
		bit                         seed_write;
		logic                       req_type;
		logic [mslrd_pkg::ValW-1:0] low_bound;
		logic [mslrd_pkg::ValW-1:0] high_bound;
		bit                         typed;
		draw_result_t               want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	mslrd_cfg_if cfg_ch();
	mslrd_req_if req_ch();
	mslrd_rsp_if rsp_ch();

	minimal_standard_lcg_range_draw DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [mslrd_pkg::ValW-1:0] gen_state;
	draw_result_t               expected_draws[$];
	int                         mismatch_count;
	bit                         gaps_on;
	stim_row_t                  directed_rows[DirRows];

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [mslrd_pkg::ValW-1:0] park_miller_next(
		input logic [mslrd_pkg::ValW-1:0] x);
		logic [63:0] hi_p;
		logic [63:0] lo_p;
		logic [63:0] nx;
		hi_p = 64'(mslrd_pkg::LcgMult) * (64'(x) % SchrageQ);
		lo_p = SchrageR * (64'(x) / SchrageQ);
		nx = (hi_p >= lo_p) ? hi_p - lo_p : hi_p + 64'(mslrd_pkg::LcgMod) - lo_p;
		return nx[mslrd_pkg::ValW-1:0];
	endfunction

	function automatic draw_result_t predict_draw(input logic t,
		input logic [mslrd_pkg::ValW-1:0] lo, input logic [mslrd_pkg::ValW-1:0] hi);
		draw_result_t r;
		logic [63:0]  k;
		logic [63:0]  limit;
		logic [63:0]  scaled;
		r = '0;
		if (t == mslrd_pkg::ReqRaw) begin
			gen_state = park_miller_next(gen_state);
			r.value = gen_state;
		end else if (hi <= lo) begin
			r.range_error = 1'b1;
		end else begin
			k = 64'(hi) - 64'(lo);
			limit = 64'(mslrd_pkg::LcgMod) - (64'(mslrd_pkg::LcgMod) % k);
			gen_state = park_miller_next(gen_state);
			while (64'(gen_state) >= limit)
				gen_state = park_miller_next(gen_state);
			scaled = (64'(gen_state) * k) / (64'(mslrd_pkg::LcgMod) - 64'd1);
			r.value = mslrd_pkg::ValW'(64'(lo) + scaled);
		end
		return r;
	endfunction

	task automatic push_request(input logic t, input logic [mslrd_pkg::ValW-1:0] lo,
		input logic [mslrd_pkg::ValW-1:0] hi, input bit typed, input draw_result_t want);
		draw_result_t predicted;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= t;
		req_ch.low_bound  <= lo;
		req_ch.high_bound <= hi;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = predict_draw(t, lo, hi);
		expected_draws.push_back(typed ? want : predicted);
	endtask

	task automatic load_seed(input logic [mslrd_pkg::ValW-1:0] s);
		req_ch.valid <= 1'b0;
		while (expected_draws.size() != 0) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.seed  <= s;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		gen_state = s;
	endtask

	// response side: checker and random stalls
	initial begin
		int           stall_left;
		draw_result_t want;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_draws.size() == 0) begin
					$error("unexpected result: value %0h range_error %0b", rsp_ch.value,
						rsp_ch.range_error);
					mismatch_count++;
				end else begin
					want = expected_draws.pop_front();
					if (rsp_ch.value !== want.value) begin
						$error("value: expected %0h, actual %0h", want.value, rsp_ch.value);
						mismatch_count++;
					end
					if (rsp_ch.range_error !== want.range_error) begin
						$error("range_error: expected %0b, actual %0b", want.range_error,
							rsp_ch.range_error);
						mismatch_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [63:0]                acc;
		logic [63:0]                base;
		logic [63:0]                e;
		logic [mslrd_pkg::ValW-1:0] one_seed;
		logic [mslrd_pkg::ValW-1:0] lo;
		logic [mslrd_pkg::ValW-1:0] hi;
		logic [mslrd_pkg::ValW-1:0] tmp;
		logic [mslrd_pkg::ValW-1:0] phase_seed[Phases];
		logic                       t;
		int unsigned                k;
		int unsigned                pick;
		arst_n            = 1'b0;
		mismatch_count    = 0;
		gaps_on           = 1'b1;
		gen_state         = mslrd_pkg::SeedReset;
		cfg_ch.valid      = 1'b0;
		cfg_ch.seed       = '0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = mslrd_pkg::ReqRaw;
		req_ch.low_bound  = '0;
		req_ch.high_bound = '0;

		// seed whose next state is m-1: m minus the inverse of the multiplier
		acc = 64'd1;
		base = 64'(mslrd_pkg::LcgMult);
		e = 64'(mslrd_pkg::LcgMod) - 64'd2;
		while (e != 0) begin
			if (e[0])
				acc = (acc * base) % 64'(mslrd_pkg::LcgMod);
			base = (base * base) % 64'(mslrd_pkg::LcgMod);
			e = e >> 1;
		end
		one_seed = mslrd_pkg::ValW'(64'(mslrd_pkg::LcgMod) - acc);

		directed_rows[0]  = '{0, mslrd_pkg::ReqRaw, '0, '0,
			1, '{31'd48271, 1'b0}};
		directed_rows[1]  = '{0, mslrd_pkg::ReqBounded, '0, '0,
			1, '{'0, 1'b1}};
		directed_rows[2]  = '{0, mslrd_pkg::ReqBounded, mslrd_pkg::LcgMod, '0,
			1, '{'0, 1'b1}};
		directed_rows[3]  = '{0, mslrd_pkg::ReqBounded, mslrd_pkg::LcgMod, mslrd_pkg::LcgMod,
			1, '{'0, 1'b1}};
		directed_rows[4]  = '{0, mslrd_pkg::ReqRaw, mslrd_pkg::LcgMod, mslrd_pkg::LcgMod,
			0, '{'0, 1'b0}};
		directed_rows[5]  = '{0, mslrd_pkg::ReqBounded, '0, mslrd_pkg::LcgMod,
			0, '{'0, 1'b0}};
		directed_rows[6]  = '{0, mslrd_pkg::ReqBounded, TopSeed, mslrd_pkg::LcgMod,
			0, '{'0, 1'b0}};
		directed_rows[7]  = '{0, mslrd_pkg::ReqBounded, '0, 31'd1,
			0, '{'0, 1'b0}};
		directed_rows[8]  = '{0, mslrd_pkg::ReqBounded, '0, HalfPlus,
			0, '{'0, 1'b0}};
		directed_rows[9]  = '{0, mslrd_pkg::ReqBounded, 31'd100, 31'd99,
			1, '{'0, 1'b1}};
		directed_rows[10] = '{1, mslrd_pkg::ReqRaw, '0, '0,
			0, '{'0, 1'b0}};
		directed_rows[11] = '{0, mslrd_pkg::ReqRaw, '0, '0,
			1, '{'0, 1'b0}};
		directed_rows[12] = '{0, mslrd_pkg::ReqBounded, 31'd5, 31'd10,
			1, '{31'd5, 1'b0}};
		directed_rows[13] = '{0, mslrd_pkg::ReqBounded, '0, mslrd_pkg::LcgMod,
			1, '{'0, 1'b0}};
		directed_rows[14] = '{1, mslrd_pkg::ReqRaw, mslrd_pkg::LcgMod, '0,
			0, '{'0, 1'b0}};
		directed_rows[15] = '{0, mslrd_pkg::ReqRaw, '0, '0,
			1, '{'0, 1'b0}};
		directed_rows[16] = '{0, mslrd_pkg::ReqRaw, mslrd_pkg::LcgMod, '0,
			1, '{'0, 1'b0}};
		directed_rows[17] = '{1, mslrd_pkg::ReqRaw, one_seed, '0,
			0, '{'0, 1'b0}};
		directed_rows[18] = '{0, mslrd_pkg::ReqBounded, TopSeed, mslrd_pkg::LcgMod,
			1, '{mslrd_pkg::LcgMod, 1'b0}};
		directed_rows[19] = '{1, mslrd_pkg::ReqRaw, TopSeed, '0,
			0, '{'0, 1'b0}};
		directed_rows[20] = '{0, mslrd_pkg::ReqRaw, '0, '0,
			0, '{'0, 1'b0}};
		directed_rows[21] = '{0, mslrd_pkg::ReqBounded, '0, 31'd3,
			0, '{'0, 1'b0}};
		directed_rows[22] = '{1, mslrd_pkg::ReqRaw, 31'd1, '0,
			0, '{'0, 1'b0}};
		directed_rows[23] = '{0, mslrd_pkg::ReqRaw, '0, '0,
			1, '{31'd48271, 1'b0}};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].seed_write)
				load_seed(directed_rows[i].low_bound);
			else
				push_request(directed_rows[i].req_type, directed_rows[i].low_bound,
					directed_rows[i].high_bound, directed_rows[i].typed, directed_rows[i].want);
		end

		phase_seed[0] = 31'd1;
		phase_seed[1] = TopSeed;
		for (int p = 2; p < Phases; p++)
			phase_seed[p] = mslrd_pkg::ValW'($urandom_range(1, 32'h7FFF_FFFE));

		for (int p = 0; p < Phases; p++) begin
			load_seed(phase_seed[p]);
			gaps_on = (p != Phases - 1);
			for (int n = 0; n < PhaseReqs; n++) begin
				pick = $urandom_range(0, 9);
				lo = mslrd_pkg::ValW'($urandom);
				hi = mslrd_pkg::ValW'($urandom);
				if (pick < 3) begin
					t = mslrd_pkg::ReqRaw;
				end else if (pick == 3) begin
					// malformed range
					t = mslrd_pkg::ReqBounded;
					if ($urandom_range(0, 3) == 0)
						hi = lo;
					else if (hi > lo) begin
						tmp = hi;
						hi = lo;
						lo = tmp;
					end
				end else begin
					t = mslrd_pkg::ReqBounded;
					case ($urandom_range(0, 4))
						0: k = $urandom_range(1, 16);
						1: k = $urandom_range(1, 65536);
						2: k = $urandom_range(1, 32'h7FFF_FFFF);
						3: k = $urandom_range(32'h4000_0001, 32'h7FFF_FFFF);
						default: k = 32'd1 << $urandom_range(0, 30);
					endcase
					lo = mslrd_pkg::ValW'($urandom_range(0, 32'h7FFF_FFFF - k));
					hi = mslrd_pkg::ValW'(32'(lo) + k);
				end
				push_request(t, lo, hi, 1'b0, '0);
			end
		end

		req_ch.valid <= 1'b0;
		while (expected_draws.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("minimal_standard_lcg_range_draw_test: done, clean");
		else
			$display("minimal_standard_lcg_range_draw_test: done, errors");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("minimal_standard_lcg_range_draw_test: done, errors");
		$finish;
	end

endmodule

// ===== minimal_standard_lcg_range_draw.f =====
rtl/mslrd_pkg.sv
rtl/mslrd_if.sv
rtl/mslrd_lcg_step.sv
rtl/mslrd_mod_unit.sv
rtl/mslrd_scale_unit.sv
rtl/minimal_standard_lcg_range_draw.sv
tb/minimal_standard_lcg_range_draw_test.sv
